/* design/hashed_key_value_lookup_engine_unit_assert.svh */
// assertion macros used by the lookup engine design file
`ifndef HASHED_KEY_VALUE_LOOKUP_ENGINE_UNIT_ASSERT_SVH
`define HASHED_KEY_VALUE_LOOKUP_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HKV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define HKV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/hkv_pkg.sv */
package hkv_pkg;

  localparam int KEY_WORDS   = 16;
  localparam int KW_BITS     = $clog2(KEY_WORDS);
  localparam int KLEN_W      = KW_BITS + 1;
  localparam int BUCKETS     = 4096;
  localparam int BUCKET_BITS = $clog2(BUCKETS);
  localparam int WAYS        = 4;
  localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef enum logic [2:0] {
    OP_CLEAR_TABLE = 3'd0,
    OP_APPEND      = 3'd1,
    OP_INSERT      = 3'd2,
    OP_LOOKUP      = 3'd3,
    OP_CLEAR_KEY   = 3'd4
  } op_t;

  typedef struct packed {
    logic [WAYS-1:0]             valid;
    logic [WAYS-1:0][KLEN_W-1:0] len;
  } meta_t;

  typedef struct packed {
    logic init;
    logic step;
    logic fin1;
    logic fin2;
  } hash_ctl_t;

  function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [31:0] w);
    logic [31:0] a;
    logic [31:0] t;
    logic [31:0] b;
    a = h + {16'd0, w[15:0]};
    t = {w[31:16], 11'd0} ^ a;
    b = {a[15:0], 16'd0} ^ t;
    return b + (b >> 11);
  endfunction

  function automatic logic [31:0] hash_fin1(input logic [31:0] h);
    logic [31:0] a;
    a = h ^ (h << 3);
    return a + (a >> 5);
  endfunction

  function automatic logic [31:0] hash_fin2(input logic [31:0] h);
    logic [31:0] a;
    logic [31:0] b;
    a = h ^ (h << 2);
    b = a + (a >> 15);
    return b ^ (b << 10);
  endfunction

endpackage

/* design/hkv_hash.sv */
module hkv_hash (
  input  logic                     clk,
  input  hkv_pkg::hash_ctl_t       ctl,
  input  logic [hkv_pkg::KLEN_W-1:0] seed_len,
  input  logic [31:0]              word,
  output logic [31:0]              hash
);

  logic [31:0] h_r;

  // one key word per step, then two finishing steps
  always_ff @(posedge clk) begin
    if (ctl.init) begin
      h_r <= {{(30 - hkv_pkg::KLEN_W){1'b0}}, seed_len, 2'b00};
    end else if (ctl.step) begin
      h_r <= hkv_pkg::hash_step(h_r, word);
    end else if (ctl.fin1) begin
      h_r <= hkv_pkg::hash_fin1(h_r);
    end else if (ctl.fin2) begin
      h_r <= hkv_pkg::hash_fin2(h_r);
    end
  end

  assign hash = h_r;

endmodule

/* design/hashed_key_value_lookup_engine_unit.sv */
// channel   ports                                       handshake
// in        in_opcode, in_data_word                     start & !busy
// out       out_result_value, out_found,                out_valid, one cycle
//           out_key_overflow, out_table_full
//
// append, clear key and unused opcodes: result in the cycle after accept, no busy.
// lookup and insert: busy high while the key is hashed, one word per cycle, and
// the key word memory is scanned, one row per cycle.
// clear table and reset: a sweep over all BUCKETS rows (4096) of the bucket
// memory with busy high; reset gives no result item.
// the receiver cannot stall: each result is shown for one cycle.
module hashed_key_value_lookup_engine_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [31:0] in_data_word,
  output logic        out_valid,
  output logic [31:0] out_result_value,
  output logic        out_found,
  output logic        out_key_overflow,
  output logic        out_table_full
);

  `include "hashed_key_value_lookup_engine_unit_assert.svh"

  localparam int KW   = hkv_pkg::KEY_WORDS;
  localparam int KB   = hkv_pkg::KW_BITS;
  localparam int KL   = hkv_pkg::KLEN_W;
  localparam int BB   = hkv_pkg::BUCKET_BITS;
  localparam int NW   = hkv_pkg::WAYS;
  localparam int WB   = hkv_pkg::WAY_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_HASH, S_FIN1, S_FIN2, S_META, S_CMP, S_RESOLVE, S_VAL, S_WRKEY
  } state_t;

  state_t            state_r;
  logic              clr_op_r;
  logic [BB-1:0]     clr_idx_r;
  logic [KL-1:0]     key_len_r;
  logic [KB-1:0]     idx_r;
  logic              is_ins_r;
  logic [31:0]       data_r;
  logic [BB-1:0]     bucket_r;
  hkv_pkg::meta_t    meta_r;
  logic [NW-1:0]     cand_r;
  logic [WB-1:0]     way_r;
  logic              out_valid_r;
  logic [31:0]       out_value_r;
  logic              out_found_r;
  logic              out_ovf_r;
  logic              out_full_r;

  logic [31:0]       kb_r [KW];
  logic [31:0]       kb_word;

  // memories
  hkv_pkg::meta_t    meta_mem [hkv_pkg::BUCKETS];
  logic [NW-1:0][31:0] kw_mem [hkv_pkg::BUCKETS * KW];
  logic [31:0]       val_mem [hkv_pkg::BUCKETS * NW];
  hkv_pkg::meta_t    meta_q;
  logic [NW-1:0][31:0] kw_q;
  logic [31:0]       val_q;

  logic              meta_we;
  logic [BB-1:0]     meta_waddr;
  hkv_pkg::meta_t    meta_wdata;
  logic [KB-1:0]     kw_raddr_w;
  logic [WB-1:0]     val_raddr_way;
  logic              val_we;
  logic              kw_we;

  hkv_pkg::hash_ctl_t hctl;
  logic [31:0]        hash;
  logic [31:0]        hash_done;

  logic [NW-1:0]     cand_base;
  logic [NW-1:0]     cand_nxt;
  logic [NW-1:0]     free;
  logic              last_idx;
  logic [WB-1:0]     hit_way;
  logic [WB-1:0]     free_way;
  logic              accept;
  hkv_pkg::meta_t    meta_new;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign kb_word = kb_r[idx_r];
  assign last_idx = (({1'b0, idx_r} + KL'(1)) >= key_len_r);
  assign hash_done = hkv_pkg::hash_fin2(hash);

  hkv_hash u_hash (
    .clk      (clk),
    .ctl      (hctl),
    .seed_len (key_len_r),
    .word     (kb_word),
    .hash     (hash)
  );

  always_comb begin
    hctl      = '0;
    hctl.init = accept && (in_opcode == hkv_pkg::OP_INSERT || in_opcode == hkv_pkg::OP_LOOKUP);
    hctl.step = (state_r == S_HASH);
    hctl.fin1 = (state_r == S_FIN1);
    hctl.fin2 = (state_r == S_FIN2);
  end

  // word compare across all ways of the bucket row
  always_comb begin
    for (int w = 0; w < NW; w++) begin
      cand_base[w] = meta_q.valid[w] && (meta_q.len[w] == key_len_r);
    end
    // first compare cycle takes valid and length from the bucket row
    if (state_r == S_CMP && idx_r == '0) begin
      cand_nxt = cand_base;
    end else begin
      cand_nxt = cand_r;
    end
    for (int w = 0; w < NW; w++) begin
      if (({1'b0, idx_r} < key_len_r) && (kw_q[w] != kb_word)) begin
        cand_nxt[w] = 1'b0;
      end
    end
  end

  always_comb begin
    hit_way  = '0;
    free_way = '0;
    free     = ~meta_r.valid;
    for (int w = NW - 1; w >= 0; w--) begin
      if (cand_r[w]) begin
        hit_way = WB'(w);
      end
      if (free[w]) begin
        free_way = WB'(w);
      end
    end
  end

  always_comb begin
    meta_new = meta_r;
    meta_new.valid[free_way] = 1'b1;
    meta_new.len[free_way]   = key_len_r;
  end

  // memory port control
  always_comb begin
    meta_we       = 1'b0;
    meta_waddr    = bucket_r;
    meta_wdata    = meta_new;
    val_we        = 1'b0;
    kw_we         = (state_r == S_WRKEY);
    val_raddr_way = hit_way;
    if (state_r == S_CLEAR) begin
      meta_we    = 1'b1;
      meta_waddr = clr_idx_r;
      meta_wdata = '0;
    end else if (state_r == S_RESOLVE && is_ins_r) begin
      if (|cand_r) begin
        val_we = 1'b1;
      end else if (|free) begin
        val_we  = 1'b1;
        meta_we = 1'b1;
      end
    end
    // read one row ahead while comparing
    if (state_r == S_CMP) begin
      kw_raddr_w = idx_r + KB'(1);
    end else begin
      kw_raddr_w = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    meta_q <= meta_mem[bucket_r];
  end

  always_ff @(posedge clk) begin
    if (kw_we) begin
      kw_mem[{bucket_r, idx_r}][way_r] <= kb_word;
    end
    kw_q <= kw_mem[{bucket_r, kw_raddr_w}];
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[{bucket_r, (|cand_r) ? hit_way : free_way}] <= data_r;
    end
    val_q <= val_mem[{bucket_r, val_raddr_way}];
  end

  always_ff @(posedge clk) begin
    if (accept && in_opcode == hkv_pkg::OP_APPEND && key_len_r < KL'(KW)) begin
      kb_r[key_len_r[KB-1:0]] <= in_data_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_op_r    <= 1'b0;
      clr_idx_r   <= '0;
      key_len_r   <= '0;
      out_valid_r <= 1'b0;
      out_value_r <= '0;
      out_found_r <= 1'b0;
      out_ovf_r   <= 1'b0;
      out_full_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      out_value_r <= '0;
      out_found_r <= 1'b0;
      out_ovf_r   <= 1'b0;
      out_full_r  <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            idx_r    <= '0;
            data_r   <= in_data_word;
            is_ins_r <= (in_opcode == hkv_pkg::OP_INSERT);
            case (in_opcode)
              hkv_pkg::OP_CLEAR_TABLE: begin
                key_len_r <= '0;
                clr_idx_r <= '0;
                clr_op_r  <= 1'b1;
                state_r   <= S_CLEAR;
              end
              hkv_pkg::OP_APPEND: begin
                out_valid_r <= 1'b1;
                if (key_len_r < KL'(KW)) begin
                  key_len_r <= key_len_r + KL'(1);
                end else begin
                  out_ovf_r <= 1'b1;
                end
              end
              hkv_pkg::OP_INSERT, hkv_pkg::OP_LOOKUP: begin
                // empty key hashes to zero with no finishing steps
                if (key_len_r == '0) begin
                  bucket_r <= '0;
                  state_r  <= S_META;
                end else begin
                  state_r <= S_HASH;
                end
              end
              hkv_pkg::OP_CLEAR_KEY: begin
                key_len_r   <= '0;
                out_valid_r <= 1'b1;
              end
              default: begin
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + BB'(1);
          if (clr_idx_r == BB'(hkv_pkg::BUCKETS - 1)) begin
            out_valid_r <= clr_op_r;
            clr_op_r    <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        S_HASH: begin
          if (last_idx) begin
            state_r <= S_FIN1;
          end else begin
            idx_r <= idx_r + KB'(1);
          end
        end
        S_FIN1: begin
          state_r <= S_FIN2;
        end
        S_FIN2: begin
          bucket_r <= hash_done[BB-1:0];
          idx_r    <= '0;
          state_r  <= S_META;
        end
        S_META: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          meta_r <= (idx_r == '0) ? meta_q : meta_r;
          cand_r <= cand_nxt;
          if (last_idx) begin
            state_r <= S_RESOLVE;
          end else begin
            idx_r <= idx_r + KB'(1);
          end
        end
        S_RESOLVE: begin
          idx_r <= '0;
          way_r <= free_way;
          if (!is_ins_r) begin
            if (|cand_r) begin
              state_r <= S_VAL;
            end else begin
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          end else if (|cand_r) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else if (|free) begin
            if (key_len_r == '0) begin
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              state_r <= S_WRKEY;
            end
          end else begin
            out_valid_r <= 1'b1;
            out_full_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_VAL: begin
          out_valid_r <= 1'b1;
          out_found_r <= 1'b1;
          out_value_r <= val_q;
          state_r     <= S_IDLE;
        end
        S_WRKEY: begin
          if (last_idx) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            idx_r <= idx_r + KB'(1);
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_found        = out_found_r;
  assign out_key_overflow = out_ovf_r;
  assign out_table_full   = out_full_r;

  `HKV_ASSERT_NEXT(a_lookup_busy,
    accept && (in_opcode == hkv_pkg::OP_LOOKUP || in_opcode == hkv_pkg::OP_INSERT),
    busy, "lookup or insert did not raise busy")
  `HKV_ASSERT_NOW(a_found_alone, out_found,
    out_valid && !out_table_full && !out_key_overflow, "found mixed with other flags")
  `HKV_ASSERT_NOW(a_key_len, 1'b1, key_len_r <= KL'(KW), "key length beyond buffer")
  `HKV_ASSERT_NOW(a_hit_only_lookup, state_r == S_VAL, !is_ins_r && (|cand_r),
    "value read without a lookup hit")

endmodule
